[hw/rtl/top_k_table_with_flash_log_unit_assert.svh]
// Assertion helpers for the top-K table block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef TOP_K_TABLE_WITH_FLASH_LOG_UNIT_ASSERT_SVH
`define TOP_K_TABLE_WITH_FLASH_LOG_UNIT_ASSERT_SVH

// same-cycle implication
`define TKFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tkfl_pkg.sv]
// ----------------------------------------------------------------------------
// tkfl_pkg
// Shared types and constants for the top-K table with flash log.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkfl_pkg;

  typedef struct packed {
    logic [7:0]  tag_first;
    logic [7:0]  tag_middle;
    logic [7:0]  tag_final;
    logic [31:0] key;
  } entry_t;

  localparam entry_t BLANK_ENTRY = '{8'h20, 8'h20, 8'h20, 32'd0};

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_CLEAR  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ACT_RECORD  = 2'd0,
    ACT_RESTORE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_EMIT_TAG = 3'd1,
    ST_EMIT_KEY = 3'd2,
    ST_ERASE    = 3'd3,
    ST_DUMP_TAG = 3'd4,
    ST_DUMP_KEY = 3'd5,
    ST_READ     = 3'd6
  } state_t;

  localparam int ADDR_W  = 18;
  localparam int OFFS_W  = 11;

  function automatic logic [31:0] pack_tags(input entry_t e);
    return {e.tag_first, e.tag_middle, e.tag_final, 8'h00};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tkfl_cell.sv]
// ----------------------------------------------------------------------------
// tkfl_cell
// One table entry of the ranking chain: compares, shifts down on insert,
// shifts up while the table is dumped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkfl_cell
  import tkfl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       prev_gt,
  input  wire entry_t     prev_entry,
  input  wire entry_t     next_entry,
  output logic            gt,
  output entry_t          entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // table is kept descending, so gt is monotone along the chain
  assign gt    = ctrl.ins.key > entry_r.key;
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (gt) begin
          entry_nxt = prev_gt ? prev_entry : ctrl.ins;
        end
      end
      CELL_CLEAR:  entry_nxt = BLANK_ENTRY;
      CELL_ROTATE: entry_nxt = next_entry;
      default:     entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= BLANK_ENTRY;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/top_k_table_with_flash_log_unit.sv]
// ----------------------------------------------------------------------------
// top_k_table_with_flash_log_unit
// Descending top-K table in a chain of cells, with a flash append log.
// ----------------------------------------------------------------------------
// Takes one item at a time. The table update happens in the cycle the item
// is accepted, then results leave through a single output register at up to
// one per cycle while out_ready is high: a record with a free log slot emits
// its tag word and then its key word, a record with the log full emits an
// erase and then rotates the table through cell 0 to write it back, a read
// emits one result, and clear or restore emit nothing.
`timescale 1ns / 1ps
`default_nettype none

`include "top_k_table_with_flash_log_unit_assert.svh"

module top_k_table_with_flash_log_unit
  import tkfl_pkg::*;
#(
  parameter int TABLE_DEPTH      = 8,
  parameter int LAST_SLOT_OFFSET = 1016
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_write_en,
  input  wire logic [7:0]  cfg_write_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_tag_first,
  input  wire logic [7:0]  in_tag_middle,
  input  wire logic [7:0]  in_tag_final,
  input  wire logic [7:0]  in_marker_byte,
  input  wire logic [31:0] in_key_value,
  input  wire logic [4:0]  in_entry_index,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [17:0]      out_flash_address,
  output logic [31:0]      out_word_data,
  output logic [31:0]      out_entry_key,
  output logic             out_final_item
);

  localparam int CNT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0]  LAST_CNT    = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [OFFS_W-1:0] LAST_SLOT   = OFFS_W'(LAST_SLOT_OFFSET);
  localparam logic [OFFS_W-1:0] FULL_OFFSET = OFFS_W'(TABLE_DEPTH * 8);

  // configuration
  logic [7:0] base_kb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_kb_r <= 8'd0;
    end else if (cfg_write_en) begin
      base_kb_r <= cfg_write_data;
    end
  end

  logic [ADDR_W-1:0] base_addr;
  assign base_addr = {base_kb_r, 10'd0};

  // control state
  state_t            state_r, state_nxt;
  logic [OFFS_W-1:0] log_offset_r, log_offset_nxt;
  logic              scan_stopped_r, scan_stopped_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OFFS_W-1:0] slot_r;
  entry_t            item_r;
  logic [4:0]        idx_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [31:0]       out_word_r;
  logic [31:0]       out_key_r;
  logic              out_final_r;

  logic              ld;
  logic [1:0]        ld_kind;
  logic [ADDR_W-1:0] ld_addr;
  logic [31:0]       ld_word;
  logic [31:0]       ld_key;
  logic              ld_final;

  logic       in_fire;
  logic       out_free;
  logic       room;
  action_t    in_act;
  cell_ctrl_t cctrl;
  entry_t     in_entry;

  // cell chain
  entry_t                 cells [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gts;
  entry_t                 rd_entry;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign room     = log_offset_r <= LAST_SLOT;
  assign in_act   = action_t'(in_action);
  assign in_entry = '{in_tag_first, in_tag_middle, in_tag_final, in_key_value};

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
        tkfl_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (cctrl),
          .prev_gt    (1'b0),
          .prev_entry (BLANK_ENTRY),
          .next_entry (cells[(i + 1) % TABLE_DEPTH]),
          .gt         (gts[i]),
          .entry      (cells[i])
        );
      end else begin : g_body
        tkfl_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (cctrl),
          .prev_gt    (gts[i-1]),
          .prev_entry (cells[i-1]),
          .next_entry (cells[(i + 1) % TABLE_DEPTH]),
          .gt         (gts[i]),
          .entry      (cells[i])
        );
      end
    end
  endgenerate

  // entry read: no match reads as all zero
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (idx_r == 5'(i)) begin
        rd_entry = cells[i];
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    log_offset_nxt   = log_offset_r;
    scan_stopped_nxt = scan_stopped_r;
    cnt_nxt          = cnt_r;
    cctrl.op         = CELL_HOLD;
    cctrl.ins        = in_entry;
    ld               = 1'b0;
    ld_kind          = KIND_WRITE;
    ld_addr          = '0;
    ld_word          = '0;
    ld_key           = '0;
    ld_final         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_act)
            ACT_RECORD: begin
              cctrl.op = CELL_INSERT;
              if (room) begin
                log_offset_nxt = log_offset_r + OFFS_W'(8);
                state_nxt      = ST_EMIT_TAG;
              end else begin
                log_offset_nxt = FULL_OFFSET;
                state_nxt      = ST_ERASE;
              end
            end
            ACT_RESTORE: begin
              if (!scan_stopped_r) begin
                if (!room || in_marker_byte != 8'd0) begin
                  scan_stopped_nxt = 1'b1;
                end else begin
                  cctrl.op       = CELL_INSERT;
                  log_offset_nxt = log_offset_r + OFFS_W'(8);
                end
              end
            end
            ACT_CLEAR: begin
              cctrl.op         = CELL_CLEAR;
              log_offset_nxt   = '0;
              scan_stopped_nxt = 1'b0;
            end
            ACT_READ: state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EMIT_TAG: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_addr   = base_addr + ADDR_W'(slot_r);
          ld_word   = pack_tags(item_r);
          state_nxt = ST_EMIT_KEY;
        end
      end
      ST_EMIT_KEY: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_addr   = base_addr + ADDR_W'(slot_r) + ADDR_W'(4);
          ld_word   = item_r.key;
          ld_final  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERASE: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = KIND_ERASE;
          ld_addr   = base_addr;
          cnt_nxt   = '0;
          state_nxt = ST_DUMP_TAG;
        end
      end
      ST_DUMP_TAG: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_addr   = base_addr + ADDR_W'({cnt_r, 3'b000});
          ld_word   = pack_tags(cells[0]);
          state_nxt = ST_DUMP_KEY;
        end
      end
      ST_DUMP_KEY: begin
        if (out_free) begin
          // cell 0 is captured, then the chain rotates up by one
          ld       = 1'b1;
          ld_addr  = base_addr + ADDR_W'({cnt_r, 3'b100});
          ld_word  = cells[0].key;
          cctrl.op = CELL_ROTATE;
          if (cnt_r == LAST_CNT) begin
            ld_final  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = ST_DUMP_TAG;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = KIND_READ;
          ld_word   = pack_tags(rd_entry);
          ld_key    = rd_entry.key;
          ld_final  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = ld ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      log_offset_r   <= '0;
      scan_stopped_r <= 1'b0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      log_offset_r   <= log_offset_nxt;
      scan_stopped_r <= scan_stopped_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_entry;
      idx_r  <= in_entry_index;
      slot_r <= log_offset_r;
    end
    if (ld) begin
      out_kind_r  <= ld_kind;
      out_addr_r  <= ld_addr;
      out_word_r  <= ld_word;
      out_key_r   <= ld_key;
      out_final_r <= ld_final;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_flash_address = out_addr_r;
  assign out_word_data     = out_word_r;
  assign out_entry_key     = out_key_r;
  assign out_final_item    = out_final_r;

  `TKFL_ASSERT_NXT(a_record_emits, in_fire && in_act == ACT_RECORD, state_r == ST_EMIT_TAG || state_r == ST_ERASE, "record item did not start emitting")

  `TKFL_ASSERT_IMP(a_erase_not_final, out_valid_r && out_kind_r == KIND_ERASE, !out_final_r, "erase marked as final result")

  `TKFL_ASSERT_IMP(a_dump_cnt, state_r == ST_DUMP_TAG || state_r == ST_DUMP_KEY, cnt_r <= LAST_CNT, "dump counter past table end")

  generate
    for (genvar i = 1; i < TABLE_DEPTH; i++) begin : g_chk
      `TKFL_ASSERT_IMP(a_sorted, state_r == ST_IDLE, cells[i-1].key >= cells[i].key, "table out of order")
    end
  endgenerate

endmodule

`default_nettype wire

[tb/tkfl_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkfl_tb_pkg
// Checker for the top-K table with flash log: keeps its own copy of the
// ranking table and log pointer, expands each accepted item into the flash
// operations and read data it should produce, and matches them in order
// against what the block emits.
// ----------------------------------------------------------------------------

package tkfl_tb_pkg;
  import tkfl_pkg::*;

  localparam int          RANK_DEPTH = 8;
  localparam logic [10:0] LAST_SLOT  = 11'd1016;

  typedef struct {
    action_t     action;
    logic [7:0]  tag_first;
    logic [7:0]  tag_middle;
    logic [7:0]  tag_final;
    logic [7:0]  marker;
    logic [31:0] key;
    logic [4:0]  index;
  } log_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [17:0] addr;
    logic [31:0] word;
    logic [31:0] key;
    logic        final_item;
  } flash_op_t;

  class topk_log_checker;
    entry_t      ranks[RANK_DEPTH];
    logic [10:0] log_off;
    bit          scan_done;
    logic [7:0]  base_kb;
    flash_op_t   flash_ops_q[$];
    int          errors;

    function new();
      blank_ranks();
      log_off   = '0;
      scan_done = 1'b0;
      base_kb   = '0;
      errors    = 0;
    endfunction

    function void blank_ranks();
      foreach (ranks[i]) ranks[i] = BLANK_ENTRY;
    endfunction

    function void set_base(logic [7:0] kb);
      base_kb = kb;
    endfunction

    function int pending();
      return flash_ops_q.size();
    endfunction

    // first entry with a strictly lower key takes the new one
    function void rank_insert(entry_t e);
      for (int i = 0; i < RANK_DEPTH; i++) begin
        if (e.key > ranks[i].key) begin
          for (int j = RANK_DEPTH - 1; j > i; j--) ranks[j] = ranks[j - 1];
          ranks[i] = e;
          return;
        end
      end
    endfunction

    function logic [31:0] tag_word(entry_t e);
      return {e.tag_first, e.tag_middle, e.tag_final, 8'h00};
    endfunction

    function void push_op(logic [1:0] kind, logic [17:0] addr, logic [31:0] word,
                          logic [31:0] key, logic last);
      flash_op_t op;
      op.kind       = kind;
      op.addr       = addr;
      op.word       = word;
      op.key        = key;
      op.final_item = last;
      flash_ops_q.push_back(op);
    endfunction

    function void predict_item(log_req_t r);
      entry_t      e;
      logic [17:0] base;
      logic [17:0] slot;
      e.tag_first  = r.tag_first;
      e.tag_middle = r.tag_middle;
      e.tag_final  = r.tag_final;
      e.key        = r.key;
      base         = {base_kb, 10'd0};
      case (r.action)
        ACT_RECORD: begin
          rank_insert(e);
          if (log_off <= LAST_SLOT) begin
            slot = base + 18'(log_off);
            push_op(KIND_WRITE, slot, tag_word(e), 32'd0, 1'b0);
            push_op(KIND_WRITE, slot + 18'd4, r.key, 32'd0, 1'b1);
            log_off = log_off + 11'd8;
          end else begin
            // log full: erase, then write the whole table back from the top
            push_op(KIND_ERASE, base, 32'd0, 32'd0, 1'b0);
            for (int i = 0; i < RANK_DEPTH; i++) begin
              slot = base + 18'(i * 8);
              push_op(KIND_WRITE, slot, tag_word(ranks[i]), 32'd0, 1'b0);
              push_op(KIND_WRITE, slot + 18'd4, ranks[i].key, 32'd0,
                      i == RANK_DEPTH - 1);
            end
            log_off = 11'(RANK_DEPTH * 8);
          end
        end
        ACT_RESTORE: begin
          if (!scan_done) begin
            if (log_off > LAST_SLOT || r.marker != 8'd0) begin
              scan_done = 1'b1;
            end else begin
              rank_insert(e);
              log_off = log_off + 11'd8;
            end
          end
        end
        ACT_CLEAR: begin
          blank_ranks();
          log_off   = '0;
          scan_done = 1'b0;
        end
        default: begin
          if (r.index < RANK_DEPTH)
            push_op(KIND_READ, 18'd0, tag_word(ranks[r.index]), ranks[r.index].key, 1'b1);
          else
            push_op(KIND_READ, 18'd0, 32'd0, 32'd0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(flash_op_t got);
      flash_op_t exp;
      if (flash_ops_q.size() == 0) begin
        $error("unexpected result: kind %0d addr 0x%05h word 0x%08h",
               got.kind, got.addr, got.word);
        errors++;
        return;
      end
      exp = flash_ops_q.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.addr !== exp.addr) begin
        $error("flash_address: expected 0x%05h, got 0x%05h", exp.addr, got.addr);
        errors++;
      end
      if (got.word !== exp.word) begin
        $error("word_data: expected 0x%08h, got 0x%08h", exp.word, got.word);
        errors++;
      end
      if (got.key !== exp.key) begin
        $error("entry_key: expected 0x%08h, got 0x%08h", exp.key, got.key);
        errors++;
      end
      if (got.final_item !== exp.final_item) begin
        $error("final_item: expected %0d, got %0d", exp.final_item, got.final_item);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives records, restores, clears and reads into the top-K table block under
// several log base settings, with random idling on both handshakes and one
// long output hold-off, and checks every emitted flash operation and read.
// ----------------------------------------------------------------------------

module tb_top;
  import tkfl_pkg::*;
  import tkfl_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [7:0]  cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_tag_first;
  logic [7:0]  in_tag_middle;
  logic [7:0]  in_tag_final;
  logic [7:0]  in_marker_byte;
  logic [31:0] in_key_value;
  logic [4:0]  in_entry_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [17:0] out_flash_address;
  logic [31:0] out_word_data;
  logic [31:0] out_entry_key;
  logic        out_final_item;

  topk_log_checker log_check;

  bit gaps_on;
  bit stalls_on;
  bit hold_req;
  int rand_items;

  top_k_table_with_flash_log_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_tag_first     (in_tag_first),
    .in_tag_middle    (in_tag_middle),
    .in_tag_final     (in_tag_final),
    .in_marker_byte   (in_marker_byte),
    .in_key_value     (in_key_value),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_flash_address(out_flash_address),
    .out_word_data    (out_word_data),
    .out_entry_key    (out_entry_key),
    .out_final_item   (out_final_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        hold_req  = 1'b0;
        repeat (299) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    flash_op_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.kind       = out_kind;
        got.addr       = out_flash_address;
        got.word       = out_word_data;
        got.key        = out_entry_key;
        got.final_item = out_final_item;
        log_check.check_result(got);
      end
    end
  end

  task automatic send(action_t act, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                      logic [7:0] marker, logic [31:0] key, logic [4:0] idx);
    log_req_t r;
    r.action     = act;
    r.tag_first  = a;
    r.tag_middle = b;
    r.tag_final  = c;
    r.marker     = marker;
    r.key        = key;
    r.index      = idx;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_action      = act;
    in_tag_first   = a;
    in_tag_middle  = b;
    in_tag_final   = c;
    in_marker_byte = marker;
    in_key_value   = key;
    in_entry_index = idx;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    log_check.predict_item(r);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // small keys make ties common; the extremes show up often too
  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return 32'($urandom_range(1, 20));
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_record();
    send(ACT_RECORD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
         rand_key(), 5'($urandom));
    rand_items++;
  endtask

  task automatic rand_read();
    logic [4:0] idx;
    idx = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    send(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
         $urandom, idx);
    rand_items++;
  endtask

  task automatic rand_restore(bit allow_stop);
    logic [7:0] marker;
    marker = (allow_stop && $urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    send(ACT_RESTORE, 8'($urandom), 8'($urandom), 8'($urandom), marker,
         rand_key(), 5'($urandom));
  endtask

  task automatic noise_item();
    send(action_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), $urandom, 5'($urandom));
    rand_items++;
  endtask

  // replay a whole flash block, run off its end, then hit the full log
  task automatic fill_log();
    send(ACT_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 5'd0);
    repeat (128) rand_restore(1'b0);
    rand_restore(1'b0);
    rand_record();
    rand_record();
    repeat (3) rand_read();
  endtask

  task automatic random_mix(int target);
    rand_items = 0;
    while (rand_items < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 6)) rand_record();
        4, 5: begin
          send(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               $urandom, 5'($urandom));
          rand_items++;
          repeat ($urandom_range(1, 12)) begin
            rand_restore(1'b1);
            rand_items++;
          end
        end
        6, 7: repeat ($urandom_range(1, 4)) rand_read();
        default: repeat ($urandom_range(1, 3)) noise_item();
      endcase
    end
  endtask

  task automatic settle();
    go_quiet();
    while (log_check.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_log_base(logic [7:0] kb);
    settle();
    @(negedge clk);
    cfg_write_en   = 1'b1;
    cfg_write_data = kb;
    @(negedge clk);
    cfg_write_en   = 1'b0;
    log_check.set_base(kb);
  endtask

  initial begin
    log_check      = new();
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_req       = 1'b0;
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    in_action      = ACT_CLEAR;
    in_tag_first   = '0;
    in_tag_middle  = '0;
    in_tag_final   = '0;
    in_marker_byte = '0;
    in_key_value   = '0;
    in_entry_index = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset table, ties, zero key, out-of-range reads, restore scan
    send(ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 32'd0,         5'd0);
    send(ACT_RECORD,  8'hFF, 8'hFF, 8'hFF, 8'h00, 32'd0,         5'd0);
    send(ACT_RECORD,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    send(ACT_RECORD,  8'h00, 8'h00, 8'h00, 8'h00, 32'd5,         5'd0);
    send(ACT_RECORD,  8'h01, 8'h02, 8'h03, 8'h00, 32'd5,         5'd0);
    send(ACT_RECORD,  8'h80, 8'h7F, 8'h81, 8'h00, 32'd1,         5'd0);
    for (int i = 0; i < 4; i++)
      send(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 5'(i));
    send(ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 32'd0,         5'd8);
    send(ACT_READ,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    send(ACT_RESTORE, 8'h41, 8'h42, 8'h43, 8'h00, 32'd100,       5'd0);
    send(ACT_RESTORE, 8'h44, 8'h45, 8'h46, 8'hFF, 32'd200,       5'd0);
    send(ACT_RESTORE, 8'h47, 8'h48, 8'h49, 8'h00, 32'd300,       5'd0);
    send(ACT_RECORD,  8'h4A, 8'h4B, 8'h4C, 8'h00, 32'd7,         5'd0);
    send(ACT_RESTORE, 8'h4D, 8'h4E, 8'h4F, 8'h00, 32'd400,       5'd0);
    send(ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 32'd0,         5'd1);
    send(ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 32'd0,         5'd7);
    send(ACT_CLEAR,   8'h00, 8'h00, 8'h00, 8'h00, 32'd0,         5'd0);
    send(ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 32'd0,         5'd0);

    // sink holds off while records keep coming, so the block backs up
    hold_req = 1'b1;
    repeat (10) rand_record();
    random_mix(10);

    set_log_base(8'($urandom_range(1, 254)));
    random_mix(10);

    set_log_base(8'hFF);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_mix(8);
    fill_log();

    go_quiet();
    while (log_check.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (log_check.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
